FILE: rtl/core/tsm_pkg.sv
package tsm_pkg;

   localparam int COORD_FRACTION_BITS = 16;
   localparam int PIXEL_BITS          = 16;

   localparam int COORD_W    = COORD_FRACTION_BITS;
   localparam int SIZE_W     = 15;
   localparam int ORIGIN_W   = 16;
   localparam int EPOCH_W    = 32;
   localparam int SCR_W      = PIXEL_BITS + 1;
   localparam int PROD_W     = COORD_W + SIZE_W;
   localparam int NUM_W      = PROD_W + 1;
   localparam int DEN_W      = COORD_W + 1;
   localparam int QUOT_W     = SIZE_W;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Packed edges: low half zero, high half full scale.
   localparam logic [CSR_DATA_W-1:0] ACTIVE_RESET =
      CSR_DATA_W'(((64'd1 << COORD_W) - 64'd1) << COORD_W);

   typedef enum logic [1:0] {
      ROT_NONE,
      ROT_90,
      ROT_180,
      ROT_270
   } rot_type;

   typedef enum logic [2:0] {
      CSR_ACTIVE_H,
      CSR_ACTIVE_V,
      CSR_VP_LEFT,
      CSR_VP_TOP,
      CSR_VP_WIDTH,
      CSR_VP_HEIGHT,
      CSR_ROTATION,
      CSR_EPOCH
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0]      active_h;
      logic [CSR_DATA_W-1:0]      active_v;
      logic signed [ORIGIN_W-1:0] vp_left;
      logic signed [ORIGIN_W-1:0] vp_top;
      logic [SIZE_W-1:0]          vp_width;
      logic [SIZE_W-1:0]          vp_height;
      rot_type                    rotation;
      logic [EPOCH_W-1:0]         epoch;
   } cfg_type;

endpackage

FILE: rtl/core/tsm_if.sv
interface tsm_req_if import tsm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] point_x;
   logic [COORD_W-1:0] point_y;
   logic [EPOCH_W-1:0] epoch_tag;

   modport source (output valid, output point_x, output point_y, output epoch_tag,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input epoch_tag,
                   output ready);
endinterface

interface tsm_rsp_if import tsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    point_valid;
   logic signed [SCR_W-1:0] screen_x;
   logic signed [SCR_W-1:0] screen_y;

   modport source (output valid, output point_valid, output screen_x, output screen_y,
                   input ready);
   modport sink   (input valid, input point_valid, input screen_x, input screen_y,
                   output ready);
endinterface

FILE: rtl/core/tsm_csr.sv
module tsm_csr import tsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_ACTIVE_H:  cfg_in.active_h  = pwdata;
            CSR_ACTIVE_V:  cfg_in.active_v  = pwdata;
            CSR_VP_LEFT:   cfg_in.vp_left   = pwdata[ORIGIN_W-1:0];
            CSR_VP_TOP:    cfg_in.vp_top    = pwdata[ORIGIN_W-1:0];
            CSR_VP_WIDTH:  cfg_in.vp_width  = pwdata[SIZE_W-1:0];
            CSR_VP_HEIGHT: cfg_in.vp_height = pwdata[SIZE_W-1:0];
            CSR_ROTATION:  cfg_in.rotation  = rot_type'(pwdata[1:0]);
            CSR_EPOCH:     cfg_in.epoch     = pwdata[EPOCH_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_h  <= ACTIVE_RESET;
         cfg_ff.active_v  <= ACTIVE_RESET;
         cfg_ff.vp_left   <= '0;
         cfg_ff.vp_top    <= '0;
         cfg_ff.vp_width  <= '0;
         cfg_ff.vp_height <= '0;
         cfg_ff.rotation  <= ROT_NONE;
         cfg_ff.epoch     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Raw register bits, zero filled above each register's width.
   always_comb begin
      unique case (index)
         CSR_ACTIVE_H:  prdata = cfg_ff.active_h;
         CSR_ACTIVE_V:  prdata = cfg_ff.active_v;
         CSR_VP_LEFT:   prdata = {{(CSR_DATA_W-ORIGIN_W){1'b0}}, cfg_ff.vp_left};
         CSR_VP_TOP:    prdata = {{(CSR_DATA_W-ORIGIN_W){1'b0}}, cfg_ff.vp_top};
         CSR_VP_WIDTH:  prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cfg_ff.vp_width};
         CSR_VP_HEIGHT: prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cfg_ff.vp_height};
         CSR_ROTATION:  prdata = {{(CSR_DATA_W-2){1'b0}}, cfg_ff.rotation};
         CSR_EPOCH:     prdata = {{(CSR_DATA_W-EPOCH_W){1'b0}}, cfg_ff.epoch};
         default:       prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/tsm_divider.sv
module tsm_divider import tsm_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [QUOT_W-1:0] quot
);

   // Restoring divider, one quotient bit per stage. The low numerator bits
   // shift out of nq as the quotient bits shift in.
   logic [DEN_W-1:0]  rem_ff [QUOT_W+1];
   logic [DEN_W-1:0]  den_ff [QUOT_W+1];
   logic [QUOT_W-1:0] nq_ff  [QUOT_W+1];
   logic [DEN_W-1:0]  rem_in [QUOT_W];
   logic [QUOT_W-1:0] nq_in  [QUOT_W];

   always_comb begin
      logic [DEN_W:0]   trial;
      logic [DEN_W+1:0] diff;
      for (int k = 0; k < QUOT_W; k++) begin
         trial = {rem_ff[k], nq_ff[k][QUOT_W-1]};
         diff  = {1'b0, trial} - {2'b00, den_ff[k]};
         if (!diff[DEN_W+1]) begin
            rem_in[k] = diff[DEN_W-1:0];
            nq_in[k]  = {nq_ff[k][QUOT_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DEN_W-1:0];
            nq_in[k]  = {nq_ff[k][QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= num[NUM_W-1:QUOT_W];
         nq_ff[0]  <= num[QUOT_W-1:0];
         den_ff[0] <= den;
         for (int k = 0; k < QUOT_W; k++) begin
            rem_ff[k+1] <= rem_in[k];
            nq_ff[k+1]  <= nq_in[k];
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign quot = nq_ff[QUOT_W];

endmodule

FILE: rtl/core/tablet_to_screen_mapper_unit.sv
// Maps normalised pen points onto screen pixels: range and epoch check, rotation,
// then left + round(u * (width - 1)) per axis, halves rounded up. One point is
// taken per clock while the output is not stalled, through nineteen register
// stages, the first loaded at the edge that accepts the point: check and
// rotation, scale multiply, rounding add into the divider, fifteen restoring
// divider stages that settle one quotient bit each, and the output register.
// A stalled output holds the whole pipeline; nothing is dropped.
// Rejected points come out with point_valid low and both coordinates zero.
// Registers sit at byte offsets 4*i on the APB-style port and should be
// written only while no point is in flight.
module tablet_to_screen_mapper_unit import tsm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tsm_req_if.sink               req_bus,
   tsm_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   tsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   logic advance;

   // Stage 1: check and rotate
   logic               s1_valid_ff;
   logic               s1_ok_ff;
   logic [COORD_W-1:0] s1_ax_ff, s1_bx_ff, s1_ay_ff, s1_by_ff;
   logic               s1_ok_in;
   logic [COORD_W-1:0] s1_ax_in, s1_bx_in, s1_ay_in, s1_by_in;
   logic [COORD_W-1:0] left, right, top, bottom;
   logic [COORD_W-1:0] nx, dx, ny, dy;

   // Stage 2: scale multiply
   logic              s2_valid_ff;
   logic              s2_ok_ff;
   logic [PROD_W-1:0] s2_px_ff, s2_py_ff;
   logic [COORD_W-1:0] s2_bx_ff, s2_by_ff;
   logic [SIZE_W-1:0] span_x, span_y;

   // Divider stages
   logic [QUOT_W:0]   dv_valid_ff;
   logic [QUOT_W:0]   dv_ok_ff;
   logic [NUM_W-1:0]  num_x, num_y;
   logic [DEN_W-1:0]  den_x, den_y;
   logic [QUOT_W-1:0] quot_x, quot_y;

   // Output register
   logic                    rsp_valid_ff;
   logic                    rsp_point_valid_ff;
   logic signed [SCR_W-1:0] rsp_x_ff, rsp_y_ff;
   logic signed [SCR_W-1:0] rsp_x_in, rsp_y_in;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   assign left   = cfg.active_h[COORD_W-1:0];
   assign right  = cfg.active_h[2*COORD_W-1:COORD_W];
   assign top    = cfg.active_v[COORD_W-1:0];
   assign bottom = cfg.active_v[2*COORD_W-1:COORD_W];

   always_comb begin
      s1_ok_in = (right > left) && (bottom > top)
                 && (cfg.vp_width != '0) && (cfg.vp_height != '0)
                 && (req_bus.epoch_tag == cfg.epoch)
                 && (req_bus.point_x >= left) && (req_bus.point_x <= right)
                 && (req_bus.point_y >= top) && (req_bus.point_y <= bottom);
      nx = req_bus.point_x - left;
      dx = right - left;
      ny = req_bus.point_y - top;
      dy = bottom - top;
      unique case (cfg.rotation)
         ROT_90: begin
            s1_ax_in = dy - ny;
            s1_bx_in = dy;
            s1_ay_in = nx;
            s1_by_in = dx;
         end
         ROT_180: begin
            s1_ax_in = dx - nx;
            s1_bx_in = dx;
            s1_ay_in = dy - ny;
            s1_by_in = dy;
         end
         ROT_270: begin
            s1_ax_in = ny;
            s1_bx_in = dy;
            s1_ay_in = dx - nx;
            s1_by_in = dx;
         end
         default: begin
            s1_ax_in = nx;
            s1_bx_in = dx;
            s1_ay_in = ny;
            s1_by_in = dy;
         end
      endcase
   end

   assign span_x = cfg.vp_width - SIZE_W'(1);
   assign span_y = cfg.vp_height - SIZE_W'(1);

   // 2*n*span + d over 2*d gives the rounded ratio
   assign num_x = {s2_px_ff, 1'b0} + NUM_W'(s2_bx_ff);
   assign num_y = {s2_py_ff, 1'b0} + NUM_W'(s2_by_ff);
   assign den_x = {s2_bx_ff, 1'b0};
   assign den_y = {s2_by_ff, 1'b0};

   tsm_divider u_div_x (
      .clock   (clock),
      .advance (advance),
      .num     (num_x),
      .den     (den_x),
      .quot    (quot_x)
   );

   tsm_divider u_div_y (
      .clock   (clock),
      .advance (advance),
      .num     (num_y),
      .den     (den_y),
      .quot    (quot_y)
   );

   always_comb begin
      if (dv_ok_ff[QUOT_W]) begin
         rsp_x_in = SCR_W'($signed(cfg.vp_left)) + SCR_W'(quot_x);
         rsp_y_in = SCR_W'($signed(cfg.vp_top)) + SCR_W'(quot_y);
      end else begin
         rsp_x_in = '0;
         rsp_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_bus.valid;
         s2_valid_ff  <= s1_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[QUOT_W-1:0], s2_valid_ff};
         rsp_valid_ff <= dv_valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ok_ff           <= s1_ok_in;
         s1_ax_ff           <= s1_ax_in;
         s1_bx_ff           <= s1_bx_in;
         s1_ay_ff           <= s1_ay_in;
         s1_by_ff           <= s1_by_in;
         s2_ok_ff           <= s1_ok_ff;
         s2_px_ff           <= PROD_W'(s1_ax_ff) * PROD_W'(span_x);
         s2_py_ff           <= PROD_W'(s1_ay_ff) * PROD_W'(span_y);
         s2_bx_ff           <= s1_bx_ff;
         s2_by_ff           <= s1_by_ff;
         dv_ok_ff           <= {dv_ok_ff[QUOT_W-1:0], s2_ok_ff};
         rsp_point_valid_ff <= dv_ok_ff[QUOT_W];
         rsp_x_ff           <= rsp_x_in;
         rsp_y_ff           <= rsp_y_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_valid = rsp_point_valid_ff;
   assign rsp_bus.screen_x    = rsp_x_ff;
   assign rsp_bus.screen_y    = rsp_y_ff;

   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_point_valid_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("rejected beat carries non-zero coordinates");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({s1_valid_ff, s2_valid_ff, dv_valid_ff, rsp_valid_ff}))
      else $error("pipeline valids moved during a stall");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && advance) |=> s1_valid_ff)
      else $error("accepted beat missing from first stage");

endmodule

FILE: dv/tablet_to_screen_mapper_unit_test.sv
`timescale 1ns / 100ps

module tablet_to_screen_mapper_unit_test;
   import tsm_pkg::*;

   typedef struct {
      bit                      mapped;
      logic signed [SCR_W-1:0] x;
      logic signed [SCR_W-1:0] y;
   } screen_point_type;

   class mapping_scoreboard;
      cfg_type          regs;
      screen_point_type pending[$];
      int               mismatches;

      function new();
         regs.active_h  = ACTIVE_RESET;
         regs.active_v  = ACTIVE_RESET;
         regs.vp_left   = '0;
         regs.vp_top    = '0;
         regs.vp_width  = '0;
         regs.vp_height = '0;
         regs.rotation  = ROT_NONE;
         regs.epoch     = '0;
         mismatches     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ACTIVE_H:  regs.active_h  = value;
            CSR_ACTIVE_V:  regs.active_v  = value;
            CSR_VP_LEFT:   regs.vp_left   = value[ORIGIN_W-1:0];
            CSR_VP_TOP:    regs.vp_top    = value[ORIGIN_W-1:0];
            CSR_VP_WIDTH:  regs.vp_width  = value[SIZE_W-1:0];
            CSR_VP_HEIGHT: regs.vp_height = value[SIZE_W-1:0];
            CSR_ROTATION:  regs.rotation  = rot_type'(value[1:0]);
            CSR_EPOCH:     regs.epoch     = value[EPOCH_W-1:0];
            default: ;
         endcase
      endfunction

      // origin + round(num * (size - 1) / den), halves rounded up
      function logic [SCR_W-1:0] scale_axis(logic signed [ORIGIN_W-1:0] origin,
                                            longint unsigned num, longint unsigned den,
                                            longint unsigned size);
         longint unsigned span;
         longint unsigned quot;
         longint          pos;
         span = size - 1;
         quot = (2 * num * span + den) / (2 * den);
         pos  = origin;
         pos  = pos + longint'(quot);
         return pos[SCR_W-1:0];
      endfunction

      function screen_point_type map_point(logic [COORD_W-1:0] px,
                                           logic [COORD_W-1:0] py,
                                           logic [EPOCH_W-1:0] tag);
         longint unsigned  lft, rgt, top, bot, nx, ny, dx, dy, ax, bx, ay, by;
         screen_point_type res;
         lft = regs.active_h[COORD_W-1:0];
         rgt = regs.active_h[2*COORD_W-1:COORD_W];
         top = regs.active_v[COORD_W-1:0];
         bot = regs.active_v[2*COORD_W-1:COORD_W];
         res.mapped = 1'b0;
         res.x      = '0;
         res.y      = '0;
         if (rgt <= lft || bot <= top || regs.vp_width == 0 || regs.vp_height == 0 ||
             tag != regs.epoch || px < lft || px > rgt || py < top || py > bot)
            return res;
         nx = px - lft;
         dx = rgt - lft;
         ny = py - top;
         dy = bot - top;
         case (regs.rotation)
            ROT_90: begin
               ax = dy - ny; bx = dy; ay = nx;      by = dx;
            end
            ROT_180: begin
               ax = dx - nx; bx = dx; ay = dy - ny; by = dy;
            end
            ROT_270: begin
               ax = ny;      bx = dy; ay = dx - nx; by = dx;
            end
            default: begin
               ax = nx;      bx = dx; ay = ny;      by = dy;
            end
         endcase
         res.mapped = 1'b1;
         res.x      = scale_axis(regs.vp_left, ax, bx, regs.vp_width);
         res.y      = scale_axis(regs.vp_top, ay, by, regs.vp_height);
         return res;
      endfunction

      function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                               logic [EPOCH_W-1:0] tag);
         pending.push_back(map_point(px, py, tag));
      endfunction

      function void check_point(logic pv, logic signed [SCR_W-1:0] sx,
                                logic signed [SCR_W-1:0] sy);
         screen_point_type want;
         if (pending.size() == 0) begin
            $error("result beat with no point outstanding: point_valid %0b x %0d y %0d",
                   pv, sx, sy);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (pv !== want.mapped) begin
            $error("point_valid: expected %0b, actual %0b", want.mapped, pv);
            mismatches++;
         end
         if (sx !== want.x) begin
            $error("screen_x: expected %0d, actual %0d", want.x, sx);
            mismatches++;
         end
         if (sy !== want.y) begin
            $error("screen_y: expected %0d, actual %0d", want.y, sy);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;

   rot_type rot_list[3] = '{ROT_90, ROT_180, ROT_270};

   mapping_scoreboard board = new();

   tsm_req_if req_if();
   tsm_rsp_if rsp_if();

   tablet_to_screen_mapper_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(idx, value);
   endtask

   task automatic set_config(logic [31:0] ah, logic [31:0] av, logic [31:0] lft,
                             logic [31:0] top, logic [31:0] wid, logic [31:0] hgt,
                             logic [31:0] rot, logic [31:0] ep);
      write_csr(CSR_ACTIVE_H, ah);
      write_csr(CSR_ACTIVE_V, av);
      write_csr(CSR_VP_LEFT, lft);
      write_csr(CSR_VP_TOP, top);
      write_csr(CSR_VP_WIDTH, wid);
      write_csr(CSR_VP_HEIGHT, hgt);
      write_csr(CSR_ROTATION, rot);
      write_csr(CSR_EPOCH, ep);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                             logic [EPOCH_W-1:0] tag);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.point_x   <= px;
      req_if.point_y   <= py;
      req_if.epoch_tag <= tag;
      do @(posedge clock); while (!req_if.ready);
      board.note_point(px, py, tag);
   endtask

   // drop valid and hold until every outstanding point has come back
   task automatic drain_points();
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_between(logic [COORD_W-1:0] lo,
                                                       logic [COORD_W-1:0] hi);
      if (lo > hi)
         return COORD_W'($urandom_range(0, 16'hFFFF));
      return COORD_W'($urandom_range(lo, hi));
   endfunction

   function automatic logic [31:0] random_edges();
      logic [15:0] a, b;
      case ($urandom_range(0, 19))
         0: return ACTIVE_RESET;
         1: begin
            a = 16'($urandom_range(0, 16'hFFFF));
            return {a, a + 16'($urandom_range(0, 9))};
         end
         2, 3: begin
            a = 16'($urandom_range(0, 16'hFFF0));
            return {a + 16'($urandom_range(1, 4)), a};
         end
         default: begin
            a = 16'($urandom_range(0, 16'hFFFF));
            b = 16'($urandom_range(0, 16'hFFFF));
            return (a < b) ? {b, a} : {a, b};
         end
      endcase
   endfunction

   function automatic logic [31:0] random_size();
      logic [31:0] junk;
      junk = $urandom & 32'hFFFF_8000;
      case ($urandom_range(0, 29))
         0:       return junk;
         1, 2:    return junk | 32'd1;
         3, 4:    return junk | 32'd32767;
         5, 6:    return junk | 32'd2;
         default: return junk | $urandom_range(3, 2000);
      endcase
   endfunction

   function automatic logic [31:0] random_origin();
      logic [31:0] junk;
      junk = $urandom & 32'hFFFF_0000;
      case ($urandom_range(0, 5))
         0:       return junk | 32'h8000;
         1:       return junk | 32'h7FFF;
         default: return junk | $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   task automatic run_random_points(int count);
      logic [COORD_W-1:0] lft, rgt, top, bot, px, py;
      logic [EPOCH_W-1:0] tag;
      int                 pick;
      for (int i = 0; i < count; i++) begin
         lft  = board.regs.active_h[COORD_W-1:0];
         rgt  = board.regs.active_h[2*COORD_W-1:COORD_W];
         top  = board.regs.active_v[COORD_W-1:0];
         bot  = board.regs.active_v[2*COORD_W-1:COORD_W];
         tag  = board.regs.epoch;
         pick = $urandom_range(0, 99);
         px   = pick_between(lft, rgt);
         py   = pick_between(top, bot);
         if (pick >= 70 && pick < 78) begin
            px = $urandom_range(0, 1) ? lft : rgt;
            py = $urandom_range(0, 1) ? top : bot;
         end else if (pick >= 78 && pick < 90) begin
            px = COORD_W'($urandom_range(0, 16'hFFFF));
            py = COORD_W'($urandom_range(0, 16'hFFFF));
         end else if (pick >= 90 && pick < 95) begin
            tag = tag ^ (32'd1 << $urandom_range(0, 31));
         end else if (pick >= 95) begin
            tag = $urandom;
         end
         send_point(px, py, tag);
      end
      drain_points();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_point(rsp_if.point_valid, rsp_if.screen_x, rsp_if.screen_y);
   end

   // receiver: random stalls, plus two long hold-offs to back the pipeline up
   initial begin
      int stall;
      int beats;
      beats = 0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (beats == 150 || beats == 400) begin
            rsp_if.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         stall = receiver_steady ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         beats++;
      end
   end

   initial begin
      #2000000;
      $display("[tablet_to_screen_mapper_unit] ERROR");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.point_x   <= '0;
      req_if.point_y   <= '0;
      req_if.epoch_tag <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // out of reset the viewport is empty, so everything is rejected
      send_point(16'h0000, 16'h0000, 32'h0);
      send_point(16'hFFFF, 16'hFFFF, 32'h0);
      drain_points();

      // full tablet onto the widest viewport at the origin extremes
      set_config(ACTIVE_RESET, ACTIVE_RESET, 32'h0000_8000, 32'h0000_7FFF,
                 32'd32767, 32'd32767, 32'(ROT_NONE), 32'hDEAD_BEEF);
      send_point(16'h0000, 16'h0000, 32'hDEAD_BEEF);
      send_point(16'hFFFF, 16'hFFFF, 32'hDEAD_BEEF);
      send_point(16'h8000, 16'h7FFF, 32'hDEAD_BEEF);
      send_point(16'h1234, 16'h5678, 32'h5EAD_BEEF);
      drain_points();
      foreach (rot_list[i]) begin
         write_csr(CSR_ROTATION, 32'(rot_list[i]));
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         send_point(16'h0000, 16'hFFFF, 32'hDEAD_BEEF);
         send_point(16'h4000, 16'hC000, 32'hDEAD_BEEF);
         drain_points();
      end

      // one-pixel viewport, points on and just beyond each edge of the rectangle
      set_config(32'hC000_4000, 32'hA000_2000, 32'h0000_000A, 32'h0000_FFFB,
                 32'd1, 32'd1, 32'(ROT_NONE), 32'h0);
      send_point(16'h4000, 16'h2000, 32'h0);
      send_point(16'hC000, 16'hA000, 32'h0);
      send_point(16'h3FFF, 16'h5000, 32'h0);
      send_point(16'hC001, 16'h5000, 32'h0);
      send_point(16'h5000, 16'h1FFF, 32'h0);
      send_point(16'h5000, 16'hA001, 32'h0);
      drain_points();

      // three ways of being unconfigured: flat horizontal edges, inverted vertical edges, zero width
      set_config(32'h5000_5000, ACTIVE_RESET, 32'h0, 32'h0, 32'd100, 32'd100,
                 32'(ROT_180), 32'd7);
      send_point(16'h5000, 16'h8000, 32'd7);
      drain_points();
      set_config(ACTIVE_RESET, 32'h1000_2000, 32'h0, 32'h0, 32'd100, 32'd100,
                 32'(ROT_180), 32'd7);
      send_point(16'h5000, 16'h1800, 32'd7);
      drain_points();
      set_config(ACTIVE_RESET, ACTIVE_RESET, 32'h0, 32'h0, 32'hFFFF_8000, 32'd100,
                 32'(ROT_180), 32'd7);
      send_point(16'h5000, 16'h8000, 32'd7);
      drain_points();

      for (int phase = 0; phase < 12; phase++) begin
         sender_steady   = (phase % 4 == 1) || (phase % 4 == 3);
         receiver_steady = (phase % 4 >= 2);
         set_config(random_edges(), random_edges(), random_origin(), random_origin(),
                    random_size(), random_size(), $urandom, $urandom);
         run_random_points(40);
      end

      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[tablet_to_screen_mapper_unit] OK");
      else
         $display("[tablet_to_screen_mapper_unit] ERROR");
      $finish;
   end

endmodule
